// ----- hw/rtl/cns_pkg.sv -----
// Package for the tone-generator voice: payload structs, codes, constants
// and the elaboration-time sine table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cns_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
  localparam int PHASE_BITS       = 32;
  localparam logic [31:0] PHASE_MASK =
    32'(~((33'(1) << (32 - PHASE_BITS)) - 33'(1)) & 33'hFFFF_FFFF);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FADE_MAX = 1'b0;     // register index, taken from paddr[2]
  localparam logic [11:0] FADE_MAX_RESET = 12'd220;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;
  localparam logic SHAPE_MIX  = 1'b0;
  localparam logic SHAPE_TRI  = 1'b1;

  localparam logic [15:0] MIX_SQUARE = 16'd22938;   // 0.7 in Q15
  localparam logic [13:0] MIX_SINE   = 14'd9830;    // 0.3 in Q15
  localparam logic [15:0] GAIN_Q15   = 16'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic        mode;
    logic [31:0] phase_step;
    logic [15:0] note_samples;
    logic [15:0] level;
    logic        wave_shape;
  } cns_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } cns_out_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][15:0] sine_tab_t;

  // Quarter-wave Taylor series in Q30, evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic neg;
    f = (64'(k) << 32) / SINE_TABLE_DEPTH;
    neg = 1'b0;
    if (f < (64'd1 << 30)) begin
      g = f;
    end else if (f < (64'd1 << 31)) begin
      g = (64'd1 << 31) - f;
    end else if (f < (64'd3 << 30)) begin
      g = f - (64'd1 << 31);
      neg = 1'b1;
    end else begin
      g = (64'd1 << 32) - f;
      neg = 1'b1;
    end
    x  = (g * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) sum = 64'sd32767;
    if (neg) sum = -sum;
    return sum[15:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

`default_nettype wire

// ----- hw/rtl/chiptune_note_synthesizer_top.sv -----
// Tone-generator voice: phase accumulator, square/sine or triangle wave,
// linear fade envelope. Uses cns_pkg (types, constants, sine table).
// Sequencing: a start item is registered when accepted; a tick item holds
//   the input through 3 passes of the shared 48x16 multiplier, 16 restoring
//   divide steps and 1 saturate, and its sample then waits in ST_OUT while an
//   older sample is unaccepted. No new item is taken until the sample is out.
// Reset: synchronous, active low; no note playing, fade_max_samples = 220.
`timescale 1ns / 1ps
`default_nettype none

module chiptune_note_synthesizer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire cns_pkg::cns_in_t              in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      cns_pkg::cns_out_t             out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cns_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cns_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [cns_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV, ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [11:0]       fade_max_r, fade_max_nxt;
  logic [31:0]       phase_acc_r, phase_acc_nxt;
  logic [31:0]       step_hold_r, step_hold_nxt;
  logic [15:0]       sample_index_r, sample_index_nxt;
  logic [15:0]       length_hold_r, length_hold_nxt;
  logic [15:0]       level_hold_r, level_hold_nxt;
  logic              shape_hold_r, shape_hold_nxt;
  logic [11:0]       fade_len_r, fade_len_nxt;
  logic              note_active_r, note_active_nxt;
  // per-sample working registers
  logic              neg_r, neg_nxt;       // sign of the wave value
  logic [11:0]       n_r, n_nxt;           // envelope numerator
  logic              last_r, last_nxt;
  logic [59:0]       acc_r, acc_nxt;       // running product
  logic [11:0]       rem_r, rem_nxt;
  logic [15:0]       quo_r, quo_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  cns_pkg::cns_out_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------
  // Wave value from the current phase, looked up in the accept cycle.
  // ---------------------------------------------------------------------
  logic [cns_pkg::SINE_BITS-1:0] sine_idx;
  logic signed [15:0]            sine_val;
  logic [14:0]                   sine_abs;
  logic [28:0]                   sine_prod;
  logic signed [17:0]            sine_part;
  logic signed [17:0]            square_part;
  logic [31:0]                   tri_d;
  logic signed [17:0]            wave_val;
  logic [16:0]                   wave_mag;

  always_comb begin
    sine_idx  = phase_acc_r[31 -: cns_pkg::SINE_BITS];
    sine_val  = $signed(cns_pkg::SINE_TAB[sine_idx]);
    // table is limited to +-32767, so the magnitude fits 15 bits
    sine_abs  = sine_val[15] ? 15'(-sine_val) : sine_val[14:0];
    sine_prod = 29'(sine_abs) * 29'(cns_pkg::MIX_SINE);
    // truncate toward zero: shift the magnitude, then restore the sign
    sine_part = sine_val[15] ? -$signed({4'b0, sine_prod[28:15]})
                             :  $signed({4'b0, sine_prod[28:15]});
    square_part = phase_acc_r[31] ? -$signed({2'b0, cns_pkg::MIX_SQUARE})
                                  :  $signed({2'b0, cns_pkg::MIX_SQUARE});
    tri_d = phase_acc_r[31] ? (phase_acc_r - 32'h8000_0000)
                            : (32'h8000_0000 - phase_acc_r);
    if (step_hold_r == 32'd0) begin
      wave_val = '0;                                  // rest
    end else if (shape_hold_r == cns_pkg::SHAPE_TRI) begin
      wave_val = $signed({1'b0, tri_d[31:15]}) - 18'sd32768;
    end else begin
      wave_val = square_part + sine_part;
    end
    wave_mag = wave_val[17] ? 17'(-wave_val) : wave_val[16:0];
  end

  // Envelope numerator and end-of-note flag for the current index.
  logic [16:0] i_plus_f;
  logic [16:0] i_plus_1;
  logic [15:0] n_wide;

  always_comb begin
    i_plus_f = {1'b0, sample_index_r} + 17'(fade_len_r);
    i_plus_1 = {1'b0, sample_index_r} + 17'd1;
    if (i_plus_f > {1'b0, length_hold_r}) begin
      n_wide = length_hold_r - sample_index_r;        // fade-out wins
    end else if (sample_index_r < 16'(fade_len_r)) begin
      n_wide = sample_index_r;
    end else begin
      n_wide = 16'(fade_len_r);
    end
  end

  // Fade length for a new note: min(register, half the note), at least 1.
  logic [14:0] half_len;
  logic [11:0] fade_pick;

  always_comb begin
    half_len  = in_data.note_samples[15:1];
    fade_pick = (15'(fade_max_r) < half_len) ? fade_max_r : half_len[11:0];
    if (15'(fade_max_r) >= half_len && half_len[14:12] != 3'b0) begin
      fade_pick = fade_max_r;
    end
    if (fade_pick == 12'd0) begin
      fade_pick = 12'd1;
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier: 48 x 16, operand b picked by the sequencer.
  // ---------------------------------------------------------------------
  logic [15:0] mul_b;
  logic [63:0] mul_prod;

  always_comb begin
    case (state_r)
      ST_MUL1: mul_b = level_hold_r;
      ST_MUL2: mul_b = {4'b0, n_r};
      ST_MUL3: mul_b = cns_pkg::GAIN_Q15;
      default: mul_b = 16'd0;
    endcase
    mul_prod = 64'(acc_r[47:0]) * 64'(mul_b);
  end

  // Restoring divide step: quotient fits 16 bits because n <= F.
  logic [12:0] div_shift;
  logic        div_ge;

  always_comb begin
    div_shift = {rem_r, quo_r[15]};
    div_ge    = div_shift >= {1'b0, fade_len_r};
  end

  // Saturation of the signed quotient.
  logic [15:0] sat_sample;

  always_comb begin
    if (!neg_r) begin
      sat_sample = quo_r[15] ? 16'h7FFF : quo_r;
    end else if (quo_r > 16'h8000) begin
      sat_sample = 16'h8000;
    end else begin
      sat_sample = -quo_r;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and state update
  // ---------------------------------------------------------------------
  logic in_fire;
  logic cfg_write;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    state_nxt        = state_r;
    fade_max_nxt     = fade_max_r;
    phase_acc_nxt    = phase_acc_r;
    step_hold_nxt    = step_hold_r;
    sample_index_nxt = sample_index_r;
    length_hold_nxt  = length_hold_r;
    level_hold_nxt   = level_hold_r;
    shape_hold_nxt   = shape_hold_r;
    fade_len_nxt     = fade_len_r;
    note_active_nxt  = note_active_r;
    neg_nxt          = neg_r;
    n_nxt            = n_r;
    last_nxt         = last_r;
    acc_nxt          = acc_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;

    if (cfg_write && paddr[2] == cns_pkg::REG_FADE_MAX) begin
      fade_max_nxt = pwdata[11:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == cns_pkg::MODE_START) begin
            step_hold_nxt    = in_data.phase_step & cns_pkg::PHASE_MASK;
            length_hold_nxt  = in_data.note_samples;
            level_hold_nxt   = in_data.level;
            shape_hold_nxt   = in_data.wave_shape;
            phase_acc_nxt    = '0;
            sample_index_nxt = '0;
            fade_len_nxt     = fade_pick;
            note_active_nxt  = (in_data.note_samples != 16'd0);
          end else if (note_active_r) begin
            // latch this sample's inputs, then advance the note
            neg_nxt          = wave_val[17];
            acc_nxt          = 60'(wave_mag);
            n_nxt            = n_wide[11:0];
            last_nxt         = (i_plus_1 >= {1'b0, length_hold_r});
            sample_index_nxt = i_plus_1[15:0];
            phase_acc_nxt    = (phase_acc_r + step_hold_r) & cns_pkg::PHASE_MASK;
            if (i_plus_1 >= {1'b0, length_hold_r}) begin
              note_active_nxt = 1'b0;
            end
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        acc_nxt   = mul_prod[59:0];                 // |v| * level
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        acc_nxt   = mul_prod[59:0];                 // * n
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        // * 32767, then drop 2^31; top bit is always zero here
        rem_nxt   = mul_prod[58:47];
        quo_nxt   = mul_prod[46:31];
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? 12'(div_shift - {1'b0, fade_len_r}) : div_shift[11:0];
        quo_nxt = {quo_r[14:0], div_ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold here only while an older sample still waits
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.sample = $signed(sat_sample);
          out_data_nxt.last   = last_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fade_max_r     <= cns_pkg::FADE_MAX_RESET;
      phase_acc_r    <= '0;
      step_hold_r    <= '0;
      sample_index_r <= '0;
      length_hold_r  <= '0;
      level_hold_r   <= '0;
      shape_hold_r   <= 1'b0;
      fade_len_r     <= 12'd1;
      note_active_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fade_max_r     <= fade_max_nxt;
      phase_acc_r    <= phase_acc_nxt;
      step_hold_r    <= step_hold_nxt;
      sample_index_r <= sample_index_nxt;
      length_hold_r  <= length_hold_nxt;
      level_hold_r   <= level_hold_nxt;
      shape_hold_r   <= shape_hold_nxt;
      fade_len_r     <= fade_len_nxt;
      note_active_r  <= note_active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    n_r        <= n_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == cns_pkg::REG_FADE_MAX) ?
                     {{(cns_pkg::CFG_DATA_W-12){1'b0}}, fade_max_r} : '0;

endmodule

`default_nettype wire

// ----- tb/chiptune_note_synthesizer_top_test.sv -----
// Self-checking bench for the tone-generator voice: drives note starts and
// sample ticks, predicts every sample and checks it on the result channel.
// Depends on cns_pkg and chiptune_note_synthesizer_top only.
`timescale 1ns / 1ps

module chiptune_note_synthesizer_top_test;

  // Fixed-point constants of the voice (Q15 mix weights and output gain).
  localparam int SQUARE_Q15  = 22938;
  localparam int SINE_Q15    = 9830;
  localparam int GAIN_Q15    = 32767;
  localparam int FADE_RESET  = 220;

  // Register map: fade length at index 0, index 1 is unused and must be ignored.
  localparam logic [cns_pkg::CFG_ADDR_W-1:0] FADE_ADDR  = {cns_pkg::REG_FADE_MAX, 2'b00};
  localparam logic [cns_pkg::CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;

  localparam int SETTLE_CYCLES = 40;    // idle time after draining, before the next phase
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int PRINT_CAP     = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cns_pkg::cns_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cns_pkg::cns_out_t out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [cns_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [cns_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [cns_pkg::CFG_DATA_W-1:0] prdata;
  logic              pready;

  always #4 clk = ~clk;

  chiptune_note_synthesizer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------------
  // Voice predictor state. Mirrors the block: phase accumulator, held note
  // fields, sample position, fade length fixed at note start.
  // ---------------------------------------------------------------------------
  int          sine_q15 [cns_pkg::SINE_TABLE_DEPTH];
  int          fade_max;
  logic [31:0] tone_phase;
  logic [31:0] tone_step;
  int          tone_pos;
  int          tone_len;
  int          tone_level;
  logic        tone_tri;
  int          tone_fade;
  logic        tone_on;

  cns_pkg::cns_in_t  note_events [$];      // items waiting for the driver
  cns_pkg::cns_out_t pending_samples [$];  // predicted samples, oldest first

  int errors = 0;
  int notes_started = 0;
  int samples_checked = 0;
  int settings_used = 0;
  int idle_pct = 0;               // chance per cycle of starting an idle burst
  int hold_req = 0;               // hold-off request handed to the receiver
  int quiet_cycles = 0;

  // Quarter-wave Taylor series in Q30, rounded to Q15 and folded by quadrant.
  function automatic int taylor_sine(int k);
    longint unsigned kk;
    longint unsigned f;
    longint unsigned g;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    bit              neg;
    kk = 64'(k);
    f = (kk << 32) / cns_pkg::SINE_TABLE_DEPTH;
    neg = 1'b0;
    if (f < (64'd1 << 30)) begin
      g = f;
    end else if (f < (64'd1 << 31)) begin
      g = (64'd1 << 31) - f;
    end else if (f < (64'd3 << 30)) begin
      g = f - (64'd1 << 31);
      neg = 1'b1;
    end else begin
      g = (64'd1 << 32) - f;
      neg = 1'b1;
    end
    x = (g * 64'd1686629713) >> 30;   // times pi/2
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) / 32768;
    if (acc > 32767) acc = 32767;
    return neg ? -int'(acc) : int'(acc);
  endfunction

  // Wave value in Q15 at the current phase; a rest gives silence.
  function automatic int wave_now();
    logic [31:0]     d;
    longint unsigned tab_idx;
    int              sq;
    if (tone_step == 0) return 0;
    if (tone_tri) begin
      d = (tone_phase >= 32'h8000_0000) ? tone_phase - 32'h8000_0000
                                        : 32'h8000_0000 - tone_phase;
      return int'(d >> 15) - 32768;
    end
    tab_idx = (64'(tone_phase) * cns_pkg::SINE_TABLE_DEPTH) >> 32;
    sq = (tone_phase < 32'h8000_0000) ? SQUARE_Q15 : -SQUARE_Q15;
    return sq + (sine_q15[tab_idx] * SINE_Q15) / 32768;
  endfunction

  task automatic voice_reset();
    fade_max = FADE_RESET;
    tone_phase = '0;
    tone_step = '0;
    tone_pos = 0;
    tone_len = 0;
    tone_level = 0;
    tone_tri = 1'b0;
    tone_fade = 1;
    tone_on = 1'b0;
  endtask

  // Applies one accepted item; a tick during a note yields one sample.
  task automatic voice_step(cns_pkg::cns_in_t it);
    int                pos;
    int                fd;
    int                n;
    int                half;
    longint            num;
    longint            s;
    bit                fin;
    cns_pkg::cns_out_t res;
    if (it.mode == cns_pkg::MODE_START) begin
      tone_step = it.phase_step & cns_pkg::PHASE_MASK;
      tone_len = int'(it.note_samples);
      tone_level = int'(it.level);
      tone_tri = it.wave_shape;
      tone_phase = '0;
      tone_pos = 0;
      half = tone_len >> 1;
      fd = (fade_max < half) ? fade_max : half;
      tone_fade = (fd < 1) ? 1 : fd;
      tone_on = (tone_len != 0);
      notes_started++;
    end else if (tone_on) begin
      pos = tone_pos;
      fd = tone_fade;
      // fade-in ramp, plateau, then fade-out which takes priority
      n = (pos < fd) ? pos : fd;
      if (pos + fd > tone_len) n = tone_len - pos;
      num = longint'(wave_now()) * longint'(GAIN_Q15) * longint'(tone_level) * longint'(n);
      s = num / (longint'(fd) << 31);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      fin = (pos + 1 >= tone_len);
      res.sample = s[15:0];
      res.last = fin;
      pending_samples.push_back(res);
      tone_pos = (pos + 1) & 16'hFFFF;
      tone_phase = (tone_phase + tone_step) & cns_pkg::PHASE_MASK;
      if (fin) tone_on = 1'b0;
    end
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  task automatic push_start(logic [31:0] step, int len, int lvl, logic shape);
    cns_pkg::cns_in_t it;
    it.mode = cns_pkg::MODE_START;
    it.phase_step = step;
    it.note_samples = len[15:0];
    it.level = lvl[15:0];
    it.wave_shape = shape;
    note_events.push_back(it);
  endtask

  // Ticks carry random junk in the note fields; the block must ignore it.
  task automatic push_ticks(int count);
    cns_pkg::cns_in_t it;
    for (int k = 0; k < count; k++) begin
      it.mode = cns_pkg::MODE_TICK;
      it.phase_step = $urandom();
      it.note_samples = 16'($urandom());
      it.level = 16'($urandom());
      it.wave_shape = 1'($urandom_range(0, 1));
      note_events.push_back(it);
    end
  endtask

  function automatic logic [31:0] rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 16) return 32'hFFFF_FFFF;
    if (r < 20) return 32'h8000_0000;
    if (r < 55) return $urandom_range(1, 32'h0400_0000);
    return $urandom();
  endfunction

  function automatic int rand_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  // Mostly short notes so fade-in, plateau and fade-out all get reached.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 12);
    if (r < 93) return $urandom_range(13, 64);
    return $urandom_range(65, 300);
  endfunction

  task automatic queue_directed();
    push_ticks(1);                                                  // tick with no note
    push_start(32'h4000_0000, 1, 65535, cns_pkg::SHAPE_MIX);        // one-sample note
    push_ticks(2);                                         // second tick is past the end
    push_start(32'h1111_1111, 0, 65535, cns_pkg::SHAPE_TRI);        // zero length
    push_ticks(1);
    push_start(32'd0, 3, 65535, cns_pkg::SHAPE_MIX);                // rest
    push_ticks(3);
    push_start(32'h8000_0000, 4, 65535, cns_pkg::SHAPE_TRI);        // triangle, full scale
    push_ticks(4);
    push_start(32'hFFFF_FFFF, 65535, 65535, cns_pkg::SHAPE_MIX);    // longest note, cut short
    push_ticks(3);
    push_start(32'h1234_5678, 5, 0, cns_pkg::SHAPE_TRI);      // silent level, start mid-note
    push_ticks(2);
    push_start(32'h2000_0000, 2, 1, cns_pkg::SHAPE_MIX);            // smallest nonzero level
    push_ticks(2);
  endtask

  // Well-formed notes with random content, plus some broken sequences.
  task automatic queue_music(int budget);
    int made;
    int r;
    int len;
    int ticks;
    made = 0;
    while (made < budget) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        len = pick_len();
        ticks = len;
        r = $urandom_range(0, 99);
        if (r < 12 && len > 1) ticks = $urandom_range(0, len - 1);  // next start cuts it
        else if (r < 22) ticks = len + $urandom_range(1, 3);        // overrun, ignored
        push_start(rand_step(), len, rand_level(), 1'($urandom_range(0, 1)));
        push_ticks(ticks);
        made += 1 + ((ticks < len) ? ticks : len);
      end else if (r < 88) begin
        push_start(rand_step(), 0, rand_level(), 1'($urandom_range(0, 1)));
        push_ticks($urandom_range(1, 2));
        made += 1;
      end else if (r < 94) begin
        ticks = $urandom_range(1, 6);
        push_start($urandom(), $urandom_range(1, 65535), rand_level(),
                   1'($urandom_range(0, 1)));
        push_ticks(ticks);
        made += 1 + ticks;
      end else begin
        push_ticks($urandom_range(1, 3));
      end
    end
  endtask

  // Two-phase register write; the copy follows at the access edge.
  task automatic apb_write(logic [cns_pkg::CFG_ADDR_W-1:0] addr,
                           logic [cns_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == FADE_ADDR) fade_max = int'(data[11:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sender pause: nothing queued, nothing offered, every sample back.
  task automatic wait_drained();
    do @(negedge clk);
    while (note_events.size() != 0 || in_valid || pending_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, inserts idle bursts between them.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin : drive_items
    logic             nv;
    cns_pkg::cns_in_t nd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && in_ready) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 10) - 1;
        end else if (note_events.size() != 0) begin
          nd = note_events.pop_front();
          nv = 1'b1;
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off when requested.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin : accept_samples
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rdy = 1'b1;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // Predict on every accepted item.
  always @(posedge clk) begin : predict_items
    if (rst_n && in_valid && in_ready) voice_step(in_data);
  end

  // Check every accepted sample against the oldest prediction.
  always @(posedge clk) begin : check_samples
    cns_pkg::cns_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch("sample with none predicted", int'($signed(out_data.sample)), 0);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (out_data.sample !== want.sample)
          flag_mismatch("sample", int'($signed(out_data.sample)), int'($signed(want.sample)));
        if (out_data.last !== want.last)
          flag_mismatch("last flag", int'(out_data.last), int'(want.last));
      end
    end
  end

  // Watchdog: any handshake on any port restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence: directed notes at the reset fade length, then one random
  // phase per fade setting (smallest, largest, zero, short, random, reset
  // value). Phase 1 holds the receiver off for a long stretch; phases 2 and
  // 5 run with no idling, phase 5 being the end of the run.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int fade_plan [6];
    int idle_plan [6];
    fade_plan = '{1, 4095, 0, 5, 0, FADE_RESET};
    fade_plan[4] = $urandom_range(2, 60);
    idle_plan = '{15, 10, 0, 25, 10, 0};
    for (int k = 0; k < cns_pkg::SINE_TABLE_DEPTH; k++) sine_q15[k] = taylor_sine(k);
    voice_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 12;
    queue_directed();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = idle_plan[ph];
      apb_write(SPARE_ADDR, $urandom());
      // upper bits are junk, only the low 12 land in the register
      apb_write(FADE_ADDR, ($urandom() & 32'hFFFF_F000) | fade_plan[ph]);
      settings_used++;
      if (ph == 1) hold_req = HOLD_CYCLES;
      queue_music(195);
      wait_drained();
    end

    $display("Played %0d note starts and checked %0d samples across %0d fade settings,",
             notes_started, samples_checked, settings_used);
    $display("including rests, zero-length and cut-short notes and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cns_pkg.sv
hw/rtl/chiptune_note_synthesizer_top.sv
tb/chiptune_note_synthesizer_top_test.sv
